### sv/skh_pkg.sv
package skh_pkg;

	// Number of scanned knobs (1 to 16).
	localparam int KNOB_COUNT = 8;

	// Field widths.
	localparam int CH_W     = 4;
	localparam int SAMPLE_W = 16;
	localparam int KNOB_W   = 15;
	localparam int HYST_W   = 15;
	localparam int LEVEL_W  = 8;

	// Report level is the stored value shifted right by this amount.
	localparam int LEVEL_SHIFT = 5;

	// Knob index width, at least one bit.
	localparam int KIDX_W = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;

	// Shared adder width: holds a signed difference of two 15-bit values.
	localparam int ALU_W = KNOB_W + 2;

	// Reset value of the hysteresis register.
	localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(16);

	// Input action codes.
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// Result kind codes.
	localparam logic KIND_MUX    = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_ABS,
		S_CMP,
		S_ADV,
		S_EMIT,
		S_READ
	} state_t;

	// Operands of the shared adder: sum = a + b + cin.
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             cin;
	} alu_req_t;

	// Write request into the knob store.
	typedef struct packed {
		logic              en;
		logic [KIDX_W-1:0] idx;
		logic [KNOB_W-1:0] data;
	} store_wr_t;

endpackage

### sv/skh_channels.sv
// Configuration write channel: one register, no index.
interface skh_cfg_if import skh_pkg::*;;
	logic              valid;
	logic              ready;
	logic [HYST_W-1:0] hysteresis;

	modport source (output valid, output hysteresis, input ready);
	modport sink (input valid, input hysteresis, output ready);
endinterface

// Input item channel.
interface skh_cmd_if import skh_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink (input valid, input action, input sample, output ready);
endinterface

// Result item channel.
interface skh_rsp_if import skh_pkg::*;;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [CH_W-1:0]    channel;
	logic [LEVEL_W-1:0] level;
	logic               changed;
	logic               last;

	modport source (
		output valid, output kind, output channel, output level,
		output changed, output last, input ready
	);
	modport sink (
		input valid, input kind, input channel, input level,
		input changed, input last, output ready
	);
endinterface

### sv/skh_alu.sv
// Shared adder used by every arithmetic step of the sample sequence.
module skh_alu import skh_pkg::*; (
	input  alu_req_t         req,
	output logic [ALU_W-1:0] sum
);

	// Add with carry in; subtraction is a + ~b + 1.
	assign sum = req.a + req.b + ALU_W'(req.cin);

endmodule

### sv/skh_knob_store.sv
// Stored knob values with one write port and one read port.
module skh_knob_store import skh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  store_wr_t         wr,
	input  logic [KIDX_W-1:0] rd_idx,
	output logic [KNOB_W-1:0] rd_data
);

	logic [KNOB_W-1:0] knob_q [KNOB_COUNT];

	// Write port; all knobs read as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KNOB_COUNT; i++) begin
				knob_q[i] <= '0;
			end
		end else if (wr.en) begin
			knob_q[wr.idx] <= wr.data;
		end
	end

	// Read port.
	assign rd_data = knob_q[rd_idx];

endmodule

### sv/scanned_knob_hysteresis_filter.sv
// Scanned knob filter with hysteresis.
//
// Channels: cfg writes the 15-bit hysteresis register (reset value 16) and
// is always ready; it should only be written while the block is idle.
// cmd carries one transaction per ADC event: action 0 brings a sample for
// the channel now selected, action 1 asks for a report of all knobs.
// rsp returns results. A sample yields one transaction of kind 0 naming
// the next mux channel; a read yields KNOB_COUNT transactions of kind 1,
// one per knob in order, with last set on the final one.
// Sequencing: a sample runs through the difference, magnitude, compare
// and channel advance steps on the one shared adder, then the output
// load, which waits while the receiver stalls. A read takes one knob
// per cycle from the single read port of the knob store while the
// receiver takes results. cmd.ready is low while an item is worked on.
// Reset clears the knob store, the changed flag, the channel pointer and
// the output valid bit. When the receiver stalls, the output register
// holds its result and the sequencer waits before loading the next one;
// a new cmd transaction can still be taken while a result waits.
module scanned_knob_hysteresis_filter import skh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	skh_cfg_if.sink   cfg,
	skh_cmd_if.sink   cmd,
	skh_rsp_if.source rsp
);

	state_t            state_q, state_d;
	logic [HYST_W-1:0] hyst_q;
	logic [CH_W-1:0]   chan_q;
	logic [CH_W-1:0]   idx_q;
	logic              flag_q;
	logic              was_q;
	logic [KNOB_W-1:0] clamp_q;
	logic [ALU_W-1:0]  diff_q;
	logic [KNOB_W:0]   mag_q;

	alu_req_t          alu_req;
	logic [ALU_W-1:0]  alu_sum;
	store_wr_t         store_wr;
	logic [KIDX_W-1:0] rd_idx;
	logic [KNOB_W-1:0] rd_data;

	logic              slot_free;
	logic              load_mux;
	logic              load_report;
	logic              report_last;
	logic              accept;
	logic [CH_W-1:0]   chan_next;

	skh_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	skh_knob_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (store_wr),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !rsp.valid || rsp.ready;
	assign report_last = (idx_q == CH_W'(KNOB_COUNT - 1));

	// Channel wrap after the increment in the advance step.
	assign chan_next = (alu_sum[CH_W:0] >= (CH_W + 1)'(KNOB_COUNT)) ? '0
		: alu_sum[CH_W-1:0];

	// Sequencer: next state, adder operands and store access.
	always_comb begin
		state_d      = state_q;
		alu_req      = '0;
		store_wr     = '0;
		rd_idx       = chan_q[KIDX_W-1:0];
		load_mux     = 1'b0;
		load_report  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (cmd.action == ACT_READ) ? S_READ : S_DIFF;
				end
			end
			S_DIFF: begin
				alu_req.a   = ALU_W'(clamp_q);
				alu_req.b   = ~ALU_W'(rd_data);
				alu_req.cin = 1'b1;
				state_d     = S_ABS;
			end
			S_ABS: begin
				alu_req.a   = diff_q[ALU_W-1] ? ~diff_q : diff_q;
				alu_req.cin = diff_q[ALU_W-1];
				state_d     = S_CMP;
			end
			S_CMP: begin
				// mag + ~hyst = mag - hyst - 1, not negative when mag > hyst.
				alu_req.a = ALU_W'(mag_q);
				alu_req.b = ~ALU_W'(hyst_q);
				store_wr.en   = !alu_sum[ALU_W-1];
				store_wr.idx  = chan_q[KIDX_W-1:0];
				store_wr.data = clamp_q;
				state_d = S_ADV;
			end
			S_ADV: begin
				alu_req.a   = ALU_W'(chan_q);
				alu_req.cin = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					load_mux = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_READ: begin
				rd_idx = idx_q[KIDX_W-1:0];
				if (slot_free) begin
					load_report = 1'b1;
					if (report_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: hysteresis, channel pointer, flag, read index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q <= HYST_RESET;
			chan_q <= '0;
			flag_q <= 1'b0;
			idx_q  <= '0;
			was_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				hyst_q <= cfg.hysteresis;
			end
			if (accept) begin
				idx_q <= '0;
				was_q <= flag_q;
			end
			if (store_wr.en) begin
				flag_q <= 1'b1;
			end
			if (state_q == S_ADV) begin
				chan_q <= chan_next;
			end
			if (load_report) begin
				idx_q <= idx_q + 1'b1;
				if (report_last) begin
					flag_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers of the sample steps.
	always_ff @(posedge clk) begin
		if (accept) begin
			clamp_q <= cmd.sample[SAMPLE_W-1] ? '0 : cmd.sample[KNOB_W-1:0];
		end
		if (state_q == S_DIFF) begin
			diff_q <= alu_sum;
		end
		if (state_q == S_ABS) begin
			mag_q <= alu_sum[KNOB_W:0];
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (load_mux || load_report) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_mux) begin
			rsp.kind    <= KIND_MUX;
			rsp.channel <= chan_q;
			rsp.level   <= '0;
			rsp.changed <= 1'b0;
			rsp.last    <= 1'b1;
		end else if (load_report) begin
			rsp.kind    <= KIND_REPORT;
			rsp.channel <= idx_q;
			rsp.level   <= rd_data[LEVEL_SHIFT +: LEVEL_W];
			rsp.changed <= was_q;
			rsp.last    <= report_last;
		end
	end

endmodule

### sv/skh_checker.sv
// Port-level checks of the knob filter.
module skh_checker import skh_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_kind,
	input logic [CH_W-1:0]    rsp_channel,
	input logic [LEVEL_W-1:0] rsp_level,
	input logic               rsp_changed,
	input logic               rsp_last
);

	// A stalled result keeps its kind, channel, level and last fields.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
			&& $stable(rsp_channel) && $stable(rsp_level) && $stable(rsp_last))
		else $error("stalled result changed");

	// After a transaction is taken the block is busy for the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("ready right after acceptance");

	// A mux selection is a single result with empty report fields.
	a_mux_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_MUX |->
			rsp_last && rsp_level == '0 && !rsp_changed
			&& {1'b0, rsp_channel} < (CH_W + 1)'(KNOB_COUNT))
		else $error("malformed mux selection");

	// The final report always names the last knob.
	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_REPORT |->
			rsp_last == (rsp_channel == CH_W'(KNOB_COUNT - 1)))
		else $error("report last flag on wrong knob");

endmodule

bind scanned_knob_hysteresis_filter skh_checker u_skh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_kind    (rsp.kind),
	.rsp_channel (rsp.channel),
	.rsp_level   (rsp.level),
	.rsp_changed (rsp.changed),
	.rsp_last    (rsp.last)
);
